// ----- sv/audio_ring_playback_volume_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the audio ring playback block
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef AUDIO_RING_PLAYBACK_VOLUME_TOP_DEFINES_SVH
`define AUDIO_RING_PLAYBACK_VOLUME_TOP_DEFINES_SVH

// Condition that must hold at every edge outside reset.
`define ARPV_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define ARPV_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// ----- sv/arpv_pkg.sv -----
// ----------------------------------------------------------------------------
// arpv_pkg
// Types and fixed constants of the audio ring playback block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package arpv_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 24;
  localparam int POT_W      = 9;
  localparam int ACC_W      = 32;
  localparam int TICK_W     = 10;
  localparam int LEVEL_W    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MUTE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOST_VOL = 2'd1;

  localparam logic [15:0] DAC_MID          = 16'h8000;
  localparam logic [15:0] DAC_MASK         = 16'hFFC0;
  localparam logic [15:0] HOST_VOL_SILENT  = 16'h8000;
  localparam logic [15:0] HOST_VOL_RESET   = 16'd256;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 3'd7;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] sample_in;
    logic               stream_running;
    logic [15:0]        pot_word;
  } in_word_t;

  typedef struct packed {
    logic [15:0]        dac_word;
    logic               level_valid;
    logic [LEVEL_W-1:0] level_meter;
  } out_word_t;

  // Pot value: top five bits scaled by 8, plus 8 more when bit 10 is set.
  function automatic logic [POT_W-1:0] pot_value(input logic [15:0] w);
    logic [POT_W-1:0] hi;
    logic [POT_W-1:0] lo;
    hi = {1'b0, w[15:11], 3'b000};
    lo = {5'b00000, w[10], 3'b000};
    return hi + lo;
  endfunction

endpackage

// ----- sv/audio_ring_playback_volume_top.sv -----
// ----------------------------------------------------------------------------
// audio_ring_playback_volume_top
// Ring-buffered audio playback with volume scaling and a level meter.
// ----------------------------------------------------------------------------
//  channel  handshake              word
//  in       in_valid / in_stall    in_data  (push sample or DAC tick)
//  out      out_valid / out_stall  out_data (one per tick)
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One item per cycle while in_stall is low. A tick reads the sample store
//  into its registered read port at acceptance; the scaling stage scales and
//  meters it, and its word is loaded into the output register when that stage
//  moves on. Pushes produce no word. Reset is synchronous; the sample store
//  is not cleared. A stalled output holds the scaling stage; in_stall rises
//  only when both are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "audio_ring_playback_volume_top_defines.svh"

module audio_ring_playback_volume_top
  import arpv_pkg::*;
#(
  parameter int BUFFER_SAMPLES = 1024,
  parameter int PACKET_SAMPLES = 32,
  parameter int PACKET_COUNT   = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int AW        = $clog2(BUFFER_SAMPLES);
  localparam int WINDOW    = PACKET_COUNT * PACKET_SAMPLES;
  localparam bit SKIP_EN   = (BUFFER_SAMPLES >= WINDOW);
  localparam bit DRAIN_EN  = (WINDOW < BUFFER_SAMPLES);
  localparam int NEAR_I    = SKIP_EN ? (BUFFER_SAMPLES - WINDOW) : 0;
  localparam int WIN_I     = DRAIN_EN ? WINDOW : 0;
  localparam logic [AW-1:0] NEAR_FULL = NEAR_I[AW-1:0];
  localparam logic [AW-1:0] WIN_IDX   = WIN_I[AW-1:0];

  // configuration
  logic        mute;
  logic [15:0] host_volume;

  // indices and counters
  logic [AW-1:0]     wr_idx;
  logic [AW-1:0]     rd_idx;
  logic [AW-1:0]     rd_idx_next;
  logic [AW-1:0]     held;
  logic [TICK_W-1:0] tick_count;

  // scaling stage
  logic             s1_v;
  logic             s1_running;
  logic             s1_meter;
  logic [POT_W-1:0] s1_pot;
  logic [ACC_W-1:0] acc;
  logic [GAIN_W-1:0] gain;

  logic                in_acc;
  logic                push_acc;
  logic                tick_acc;
  logic                out_take;
  logic                s1_free;
  logic                s1_fire;
  logic [SAMPLE_W-1:0] rd_data;

  logic [SAMPLE_W:0]        mag;
  logic [ACC_W-1:0]         acc_sum;
  logic signed [PROD_W-1:0] prod;
  logic [15:0]              dac_full;
  logic [LEVEL_W-1:0]       level;
  logic [GAIN_W:0]          gain_prod;
  logic [GAIN_W-1:0]        gain_next;
  out_word_t                result;

  assign cfg_ready = 1'b1;

  assign out_take = !out_valid || !out_stall;
  assign s1_free  = !s1_v || out_take;
  assign in_stall = !s1_free;
  assign in_acc   = in_valid && !in_stall;
  assign push_acc = in_acc && (in_data.req_type == REQ_PUSH);
  assign tick_acc = in_acc && (in_data.req_type == REQ_TICK);
  assign s1_fire  = s1_v && out_take;

  // read pointer: drain above one window, skip one more when nearly full
  always_comb begin
    held        = wr_idx - rd_idx;
    rd_idx_next = rd_idx;
    if (SKIP_EN && (held == NEAR_FULL)) begin
      rd_idx_next = rd_idx_next + AW'(1);
    end
    if (DRAIN_EN && (held > WIN_IDX)) begin
      rd_idx_next = rd_idx_next + AW'(1);
    end
  end

  arpv_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (BUFFER_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (push_acc),
    .waddr (wr_idx),
    .wdata (in_data.sample_in),
    .re    (tick_acc && in_data.stream_running),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mute        <= 1'b0;
      host_volume <= HOST_VOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_MUTE) begin
        mute <= cfg_data[0];
      end else if (cfg_index == CFG_HOST_VOL) begin
        host_volume <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx     <= '0;
      rd_idx     <= '0;
      tick_count <= '0;
      s1_v       <= 1'b0;
    end else begin
      if (push_acc) begin
        wr_idx <= wr_idx + AW'(1);
      end
      if (tick_acc) begin
        tick_count <= tick_count + TICK_W'(1);
        if (in_data.stream_running) begin
          rd_idx <= rd_idx_next;
        end
      end
      if (s1_free) begin
        s1_v <= tick_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      s1_running <= in_data.stream_running;
      s1_meter   <= (tick_count == '0);
      s1_pot     <= pot_value(in_data.pot_word);
    end
  end

  // scale, meter and gain reload
  always_comb begin
    mag       = rd_data[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {rd_data[SAMPLE_W-1], rd_data})
                                    : {1'b0, rd_data};
    acc_sum   = s1_running ? (acc + ACC_W'(mag)) : acc;
    prod      = $signed(rd_data) * $signed({1'b0, gain});
    dac_full  = (s1_running && !mute) ? (prod[31:16] ^ DAC_MID) : DAC_MID;
    level     = '0;
    if (s1_meter) begin
      level = (acc_sum[ACC_W-1:20] > ACC_W'(LEVEL_MAX)) ? LEVEL_MAX
                                                         : acc_sum[22:20];
    end
    gain_prod = host_volume * s1_pot;
    gain_next = (host_volume == HOST_VOL_SILENT) ? '0 : gain_prod[GAIN_W-1:0];
    result.dac_word    = dac_full & DAC_MASK;
    result.level_valid = s1_meter;
    result.level_meter = level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      gain      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (s1_fire) begin
        acc <= s1_meter ? '0 : acc_sum;
        if (s1_meter) begin
          gain <= gain_next;
        end
      end
      if (out_take) begin
        out_valid <= s1_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data <= result;
    end
  end

  `ARPV_ASSERT_NEXT(a_push_keeps_rd, push_acc, rd_idx == $past(rd_idx),
                    "push moved read index")
  `ARPV_ASSERT_NEXT(a_stop_keeps_rd, tick_acc && !in_data.stream_running,
                    $stable(rd_idx), "stopped tick moved read index")
  `ARPV_ASSERT_NEXT(a_hold_rdata, s1_v && s1_running && !out_take, $stable(rd_data),
                    "read data lost while held")
  `ARPV_ASSERT_NEXT(a_meter_clear, s1_fire && s1_meter, acc == '0,
                    "accumulator not cleared")
  `ARPV_ASSERT_ALWAYS(a_level_quiet,
                      !out_valid || out_data.level_valid || (out_data.level_meter == '0),
                      "level without meter tick")

endmodule

// ----- sv/arpv_ram.sv -----
// ----------------------------------------------------------------------------
// arpv_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arpv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data when no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the audio ring playback block: a built-in
// predictor of the ring, volume and meter drives a queue of expected DAC
// words that each output word is checked against, under random idling,
// receiver hold-off and a range of mute and host volume settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import arpv_pkg::*;

  localparam int BUF_DEPTH    = 1024;
  localparam int PKT_SAMPLES  = 32;
  localparam int PKT_COUNT    = 4;
  localparam int READ_WINDOW  = PKT_COUNT * PKT_SAMPLES;
  localparam int DRAIN_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 400000;

  // indexes past the register list; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  in_word_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_word_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  // predictor state
  logic [15:0] ring_store [BUF_DEPTH];
  bit          ring_written [BUF_DEPTH];
  logic [9:0]  wr_ptr;
  logic [9:0]  rd_ptr;
  logic [31:0] level_sum;
  logic [23:0] gain_q;
  logic [9:0]  tick_no;
  logic        mute_q;
  logic [15:0] host_vol_q;

  out_word_t dac_pending [$];
  out_word_t seen_want;

  int  errors = 0;
  int  cycle_count = 0;
  int  pushes_sent = 0;
  int  ticks_sent = 0;
  int  meter_reports = 0;
  int  near_full_skips = 0;
  int  reg_writes = 0;
  bit  idling = 1'b1;
  int  hold_req = 0;
  int  hold_left = 0;

  audio_ring_playback_volume_top #(
    .BUFFER_SAMPLES(BUF_DEPTH),
    .PACKET_SAMPLES(PKT_SAMPLES),
    .PACKET_COUNT  (PKT_COUNT)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("audio_ring_playback_volume_top: mismatch");
      $finish;
    end
  end

  // receiver: random stall, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= idling && ($urandom_range(99) < 11);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (dac_pending.size() == 0) begin
        $error("output word with no expected word pending: %h", out_data);
        errors++;
      end else begin
        seen_want = dac_pending.pop_front();
        if (out_data.dac_word !== seen_want.dac_word) begin
          $error("dac_word expected %h got %h", seen_want.dac_word, out_data.dac_word);
          errors++;
        end
        if (out_data.level_valid !== seen_want.level_valid) begin
          $error("level_valid expected %0d got %0d", seen_want.level_valid,
                 out_data.level_valid);
          errors++;
        end
        if (out_data.level_meter !== seen_want.level_meter) begin
          $error("level_meter expected %0d got %0d", seen_want.level_meter,
                 out_data.level_meter);
          errors++;
        end
        if (seen_want.level_valid) meter_reports++;
      end
    end
  end

  function automatic logic [9:0] ring_fill();
    return wr_ptr - rd_ptr;
  endfunction

  // Advance the playback state by one word; returns 1 when a DAC word results.
  function automatic bit next_dac_word(input in_word_t w, output out_word_t r);
    logic [15:0]        raw;
    logic [9:0]         held;
    logic [16:0]        mag;
    logic signed [41:0] prod;
    logic [31:0]        vol_prod;
    logic [15:0]        pot;
    logic [15:0]        dac;
    r = '0;
    if (w.req_type == REQ_PUSH) begin
      ring_store[wr_ptr]   = w.sample_in;
      ring_written[wr_ptr] = 1'b1;
      wr_ptr = wr_ptr + 1'b1;
      return 1'b0;
    end
    dac = DAC_MID;
    if (w.stream_running) begin
      raw  = ring_store[rd_ptr];
      held = wr_ptr - rd_ptr;
      // skip one extra sample when the ring is nearly full
      if (held == 10'(BUF_DEPTH - READ_WINDOW)) begin
        rd_ptr = rd_ptr + 1'b1;
        near_full_skips++;
      end
      if (held > READ_WINDOW) rd_ptr = rd_ptr + 1'b1;
      mag = raw[15] ? 17'(17'h10000 - raw) : {1'b0, raw};
      level_sum = level_sum + mag;
      prod = $signed(raw) * $signed({18'd0, gain_q});
      dac  = prod[31:16] + DAC_MID;
    end
    if (mute_q) dac = DAC_MID;
    if (tick_no == 10'd0) begin
      pot = ((w.pot_word >> 8) & 16'h00F8) + ((w.pot_word >> 7) & 16'h0008);
      vol_prod = host_vol_q * pot;
      gain_q = (host_vol_q == HOST_VOL_SILENT) ? 24'd0 : vol_prod[23:0];
      r.level_valid = 1'b1;
      r.level_meter = (level_sum[31:20] > 7) ? LEVEL_MAX : level_sum[22:20];
      level_sum = '0;
    end
    tick_no = tick_no + 1'b1;
    r.dac_word = dac & DAC_MASK;
    return 1'b1;
  endfunction

  function automatic in_word_t mk(input logic kind, input logic [15:0] s, input logic run,
                                  input logic [15:0] pot);
    in_word_t w;
    w.req_type       = kind;
    w.sample_in      = s;
    w.stream_running = run;
    w.pot_word       = pot;
    return w;
  endfunction

  function automatic logic [15:0] pick_sample(input int amp);
    int s;
    if (amp >= 32767 && $urandom_range(9) == 0) begin
      case ($urandom_range(4))
        0: return 16'h7FFF;
        1: return 16'h8000;
        2: return 16'h0000;
        3: return 16'hFFFF;
        default: return 16'h0001;
      endcase
    end
    if (amp >= 32767) return 16'($urandom);
    s = int'($urandom_range(2 * amp)) - amp;
    return 16'(s);
  endfunction

  // Random word; never lets a tick read a ring entry that was never written.
  function automatic in_word_t make_word(input int push_pct, input int amp);
    in_word_t w;
    w.req_type  = ($urandom_range(99) < push_pct) ? REQ_PUSH : REQ_TICK;
    w.sample_in = pick_sample(amp);
    w.pot_word  = 16'($urandom);
    if (w.req_type == REQ_PUSH) w.stream_running = 1'($urandom_range(1));
    else w.stream_running = ($urandom_range(99) < 85) && ring_written[rd_ptr];
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    out_word_t want;
    if (idling && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (next_dac_word(w, want)) dac_pending.push_back(want);
    if (w.req_type == REQ_PUSH) pushes_sent++;
    else ticks_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (dac_pending.size() != 0) @(posedge clk);
    // a trailing push may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input bit touch_spare, input logic mute_v,
                              input logic [15:0] vol_v);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [15:0]          dat [4];
    int n;
    int k;
    n = 0;
    if (touch_spare) begin
      idx[0] = CFG_SPARE_LO; dat[0] = 16'($urandom);
      idx[1] = CFG_SPARE_HI; dat[1] = 16'($urandom);
      n = 2;
    end
    idx[n] = CFG_MUTE;     dat[n] = {15'($urandom), mute_v};
    idx[n+1] = CFG_HOST_VOL; dat[n+1] = vol_v;
    n = n + 2;
    cfg_valid <= 1'b1;
    for (k = 0; k < n; k++) begin
      cfg_index <= idx[k];
      cfg_data  <= dat[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      if (idx[k] == CFG_MUTE) mute_q = dat[k][0];
      else if (idx[k] == CFG_HOST_VOL) host_vol_q = dat[k];
      reg_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    // reset settings: first tick loads gain from 256 times the pot value
    send_word(mk(REQ_TICK, 16'h0000, 1'b0, 16'hFFFF));
    send_word(mk(REQ_PUSH, 16'h7FFF, 1'b0, 16'h0000));
    send_word(mk(REQ_PUSH, 16'h8000, 1'b1, 16'hFFFF));
    send_word(mk(REQ_PUSH, 16'h0000, 1'b0, 16'h0000));
    send_word(mk(REQ_PUSH, 16'hFFFF, 1'b1, 16'hFFFF));
    send_word(mk(REQ_PUSH, 16'h0001, 1'b0, 16'h0000));
    send_word(mk(REQ_TICK, 16'h0000, 1'b1, 16'h0000));
    send_word(mk(REQ_TICK, 16'hFFFF, 1'b1, 16'h0400));
    send_word(mk(REQ_TICK, 16'h8000, 1'b0, 16'hFFFF));
    wait_idle();
    program_regs(1'b1, 1'b1, HOST_VOL_SILENT);
    // muted: read and meter still happen
    send_word(mk(REQ_TICK, 16'h0000, 1'b1, 16'hFFFF));
    send_word(mk(REQ_PUSH, 16'h8000, 1'b0, 16'h0000));
    send_word(mk(REQ_TICK, 16'h7FFF, 1'b1, 16'h0000));
    wait_idle();
    program_regs(1'b0, 1'b0, 16'hFFFF);
    send_word(mk(REQ_TICK, 16'h0000, 1'b1, 16'h0400));
    send_word(mk(REQ_TICK, 16'hFFFF, 1'b0, 16'hFBFF));
  endtask

  task automatic test_fill_and_overrun();
    in_word_t w;
    int k;
    for (k = 0; k < 3; k++) begin
      while (ring_fill() != 10'(BUF_DEPTH - READ_WINDOW)) send_word(make_word(100, 32767));
      w = make_word(0, 32767);
      w.stream_running = 1'b1;
      send_word(w);
    end
    // push past full so the oldest samples are overwritten
    repeat (150) send_word(make_word(100, 32767));
    repeat (40) send_word(make_word(10, 32767));
  endtask

  task automatic test_random_traffic();
    int i;
    wait_idle();
    program_regs(1'b0, 1'b0, 16'($urandom));
    for (i = 0; i < 220; i++) begin
      if (i == 60) hold_req = 200;
      if (i == 110) begin
        wait_idle();
        program_regs(1'b0, 1'($urandom_range(1)), 16'($urandom));
      end
      if (i == 130) idling = 1'b0;
      if (i == 190) idling = 1'b1;
      send_word(make_word(50, 32767));
    end
  endtask

  // Mute acts at once; a host volume write takes hold at the next gain reload.
  task automatic test_mute_and_volume();
    logic [15:0] vols [5];
    logic        mutes [5];
    int          amps [5];
    int          p;
    int          i;
    vols  = '{16'h0000, 16'hFFFF, HOST_VOL_SILENT, 16'h7FFF, 16'($urandom)};
    mutes = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    amps  = '{300, 32767, 20000, 9000, 3000};
    for (p = 0; p < 5; p++) begin
      wait_idle();
      program_regs(1'b0, mutes[p], vols[p]);
      if (p == 1) hold_req = 120;
      for (i = 0; i < 16; i++) begin
        send_word((ring_fill() < 4) ? make_word(100, amps[p]) : make_word(40, amps[p]));
      end
    end
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_MUTE;
    cfg_data  <= '0;
    wr_ptr     = '0;
    rd_ptr     = '0;
    level_sum  = '0;
    gain_q     = '0;
    tick_no    = '0;
    mute_q     = 1'b0;
    host_vol_q = HOST_VOL_RESET;
    foreach (ring_written[k]) ring_written[k] = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_fill_and_overrun();
    test_random_traffic();
    test_mute_and_volume();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d pushes and %0d ticks, %0d level reports, %0d register writes",
             pushes_sent, ticks_sent, meter_reports, reg_writes);
    $display("nearly-full skips: %0d, checker errors: %0d", near_full_skips, errors);
    if (errors == 0 && dac_pending.size() == 0) begin
      $display("audio_ring_playback_volume_top: match");
    end else begin
      $display("audio_ring_playback_volume_top: mismatch");
    end
    $finish;
  end

endmodule
